FILE: hdl/cidw_pkg.sv
`timescale 1ns / 1ps

package cidw_pkg;

	localparam int unsigned IdWidth = 48;
	localparam logic [IdWidth-1:0] IdEmpty = {IdWidth{1'b1}};

	typedef enum logic [1:0] {
		OP_MATCH  = 2'd0,
		OP_STORE  = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_FOUND    = 3'd0,
		ST_NOTFOUND = 3'd1,
		ST_STORED   = 3'd2,
		ST_ALREADY  = 3'd3,
		ST_FULL     = 3'd4,
		ST_DELETED  = 3'd5,
		ST_CLEARED  = 3'd6
	} status_t;

	// Table update commands, one cycle each.
	typedef struct packed {
		logic wr;     // write data into a slot, mark it occupied
		logic inval;  // mark a slot empty
		logic clr;    // mark every slot empty
	} mem_ctl_t;

endpackage

FILE: hdl/cidw_req_if.sv
`timescale 1ns / 1ps

interface cidw_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    opcode;
	logic [cidw_pkg::IdWidth-1:0]  card_id;

	modport source (output valid, output opcode, output card_id, input ready);
	modport sink (input valid, input opcode, input card_id, output ready);
endinterface

FILE: hdl/cidw_rsp_if.sv
`timescale 1ns / 1ps

interface cidw_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [4:0] slot;

	modport source (output valid, output status, output slot, input ready);
	modport sink (input valid, input status, input slot, output ready);
endinterface

FILE: hdl/cidw_mem.sv
`timescale 1ns / 1ps

module cidw_mem #(
	parameter int unsigned SLOTS = 20,
	parameter int unsigned IW    = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [IW-1:0]                 rd_addr,
	output logic [cidw_pkg::IdWidth-1:0]  rd_data,
	input  cidw_pkg::mem_ctl_t            ctl,
	input  logic [IW-1:0]                 wr_addr,
	input  logic [cidw_pkg::IdWidth-1:0]  wr_data
);

	logic [cidw_pkg::IdWidth-1:0] mem [SLOTS];
	logic [SLOTS-1:0]             occ_q;
	logic [cidw_pkg::IdWidth-1:0] rd_word_q;
	logic                         rd_occ_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[wr_addr] <= wr_data;
		end
		rd_word_q <= mem[rd_addr];
	end

	// Empty slots need no clearing pass: an unoccupied slot reads as all ones.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			rd_occ_q <= 1'b0;
		end else begin
			rd_occ_q <= occ_q[rd_addr];
			if (ctl.clr) begin
				occ_q <= '0;
			end else if (ctl.wr) begin
				occ_q[wr_addr] <= 1'b1;
			end else if (ctl.inval) begin
				occ_q[wr_addr] <= 1'b0;
			end
		end
	end

	assign rd_data = rd_occ_q ? rd_word_q : cidw_pkg::IdEmpty;

endmodule

FILE: hdl/card_id_whitelist_table.sv
`timescale 1ns / 1ps
// Match, store and delete walk every slot from accept to result; clear skips the
// walk. One word is in work at a time, and the next word is taken the cycle after
// the result is registered, which waits until the receiver has taken the last one.
// Reset empties every slot at once through the occupancy flags; no sweep.

module card_id_whitelist_table #(
	parameter int unsigned SLOTS = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	cidw_req_if.sink   req,
	cidw_rsp_if.source rsp
);

	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);

	typedef enum logic [2:0] {
		S_IDLE    = 3'b001,
		S_SEARCH  = 3'b010,
		S_RESOLVE = 3'b100
	} state_t;

	state_t                        state_q;
	cidw_pkg::opcode_t             op_q;
	logic [cidw_pkg::IdWidth-1:0]  id_q;

	// Read issue side of the walk.
	logic          issue_q;
	logic [IW-1:0] rd_idx_q;

	// Compare stage: memory data returned for slot idx_s1.
	logic          vld_s1;
	logic [IW-1:0] idx_s1;

	// Lowest matching slot and lowest empty slot seen so far.
	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic          emp_q;
	logic [IW-1:0] emp_idx_q;

	logic [cidw_pkg::IdWidth-1:0]  rd_data;
	cidw_pkg::mem_ctl_t            ctl;
	logic [IW-1:0]                 wr_addr;

	logic              rsp_vld_q;
	logic [2:0]        rsp_status_q;
	logic [4:0]        rsp_slot_q;

	logic              out_free;
	logic              fin;
	cidw_pkg::status_t fin_status;
	logic [IW-1:0]     fin_idx;
	logic              fin_use_idx;
	logic [IW+4:0]     fin_idx_ext;
	logic              is_hit;
	logic              is_emp;

	cidw_mem #(
		.SLOTS (SLOTS),
		.IW    (IW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data),
		.ctl     (ctl),
		.wr_addr (wr_addr),
		.wr_data (id_q)
	);

	assign req.ready = (state_q == S_IDLE);
	assign out_free  = !rsp_vld_q || rsp.ready;
	assign fin       = (state_q == S_RESOLVE) && out_free;

	// Hit comparator of the walk; the empty test rides on the same read word.
	assign is_hit = (rd_data == id_q);
	assign is_emp = (rd_data == cidw_pkg::IdEmpty);

	// Decide the outcome once the walk is done.
	always_comb begin
		fin_status  = cidw_pkg::ST_NOTFOUND;
		fin_idx     = hit_idx_q;
		fin_use_idx = 1'b0;
		ctl         = '0;
		wr_addr     = hit_idx_q;
		case (op_q)
			cidw_pkg::OP_MATCH: begin
				if (hit_q) begin
					fin_status  = cidw_pkg::ST_FOUND;
					fin_use_idx = 1'b1;
				end
			end
			cidw_pkg::OP_STORE: begin
				if (hit_q) begin
					fin_status  = cidw_pkg::ST_ALREADY;
					fin_use_idx = 1'b1;
				end else if (emp_q) begin
					fin_status  = cidw_pkg::ST_STORED;
					fin_idx     = emp_idx_q;
					fin_use_idx = 1'b1;
					wr_addr     = emp_idx_q;
					ctl.wr      = fin;
				end else begin
					fin_status = cidw_pkg::ST_FULL;
				end
			end
			cidw_pkg::OP_DELETE: begin
				if (hit_q) begin
					fin_status  = cidw_pkg::ST_DELETED;
					fin_use_idx = 1'b1;
					ctl.inval   = fin;
				end
			end
			cidw_pkg::OP_CLEAR: begin
				fin_status = cidw_pkg::ST_CLEARED;
				ctl.clr    = fin;
			end
			default: begin
				fin_status = cidw_pkg::ST_NOTFOUND;
			end
		endcase
		// Slot field keeps the five low bits of the index.
		fin_idx_ext = {5'b0, (fin_use_idx ? fin_idx : '0)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			issue_q   <= 1'b0;
			rd_idx_q  <= '0;
			vld_s1    <= 1'b0;
			hit_q     <= 1'b0;
			emp_q     <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			// Load a new result, or drop the current one once taken.
			if (fin) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						hit_q    <= 1'b0;
						emp_q    <= 1'b0;
						rd_idx_q <= '0;
						vld_s1   <= 1'b0;
						if (cidw_pkg::opcode_t'(req.opcode) == cidw_pkg::OP_CLEAR) begin
							state_q <= S_RESOLVE;
						end else begin
							issue_q <= 1'b1;
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					// Advance the read address, one slot per cycle. The last
					// read clears issue_q, so the compare stage drains itself.
					vld_s1 <= issue_q;
					idx_s1 <= rd_idx_q;
					if (issue_q) begin
						if (rd_idx_q == LastIdx) begin
							issue_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
					// Record the first hit and the first empty slot only.
					if (vld_s1) begin
						if (is_hit && !hit_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= idx_s1;
						end
						if (is_emp && !emp_q) begin
							emp_q     <= 1'b1;
							emp_idx_q <= idx_s1;
						end
						if (idx_s1 == LastIdx) begin
							state_q <= S_RESOLVE;
						end
					end
				end
				S_RESOLVE: begin
					// Hold until the output register is free.
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers, no reset needed.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q <= cidw_pkg::opcode_t'(req.opcode);
			id_q <= req.card_id;
		end
		if (fin) begin
			rsp_status_q <= fin_status;
			rsp_slot_q   <= fin_idx_ext[4:0];
		end
	end

	assign rsp.valid  = rsp_vld_q;
	assign rsp.status = rsp_status_q;
	assign rsp.slot   = rsp_slot_q;

endmodule
